>>> rtl/core/pce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_pkg: shared types and constants
// Opcodes, status codes, the queued command record and Q16.16 saturation.
// ----------------------------------------------------------------------------
package pce_pkg;

  localparam logic [3:0] OP_SETLEN  = 4'd0;
  localparam logic [3:0] OP_WRITE   = 4'd1;
  localparam logic [3:0] OP_ADD     = 4'd2;
  localparam logic [3:0] OP_SUB     = 4'd3;
  localparam logic [3:0] OP_ADDSC   = 4'd4;
  localparam logic [3:0] OP_SCMINUS = 4'd5;
  localparam logic [3:0] OP_SCALE   = 4'd6;
  localparam logic [3:0] OP_DIVIDE  = 4'd7;
  localparam logic [3:0] OP_INTEG   = 4'd8;
  localparam logic [3:0] OP_DERIV   = 4'd9;
  localparam logic [3:0] OP_READ    = 4'd10;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  typedef struct packed {
    logic [3:0]         op;
    logic [4:0]         idx;
    logic signed [31:0] val;
    logic [1:0]         st;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/pce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/pce_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_div: signed restoring divider
// 48-bit dividend by 32-bit divisor, one quotient bit a cycle, truncating.
// ----------------------------------------------------------------------------
module pce_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [47:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [48:0] quotient
);

  logic        running;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [47:0] dq;
  logic [31:0] dmag;
  logic        neg;
  logic [32:0] sh;
  logic        fits;

  assign sh   = {rem, dq[47]};
  assign fits = sh >= {1'b0, dmag};
  assign quotient = neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= 6'd47;
        rem     <= '0;
        dq      <= dividend[47] ? 48'(-dividend) : 48'(dividend);
        dmag    <= divisor[31] ? 32'(-divisor) : 32'(divisor);
        neg     <= dividend[47] ^ divisor[31];
      end else if (running) begin
        // shift one dividend bit in, subtract when it fits
        rem <= fits ? 32'(sh - {1'b0, dmag}) : sh[31:0];
        dq  <= {dq[46:0], fits};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/pce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_front: command intake
// Accept items, check index range and divisor, queue them for the back end.
// ----------------------------------------------------------------------------
module pce_front #(
  parameter int MAX_TERMS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [3:0]          opcode,
  input  logic [4:0]          index,
  input  logic signed [31:0]  value,
  output logic                q_valid,
  output pce_pkg::cmd_t       q_cmd,
  input  logic                q_pop
);
  import pce_pkg::*;

  cmd_t       fifo [2];
  logic       wp, rp;
  logic [1:0] fill;
  logic       push, pop;
  cmd_t       cls;

  always_comb begin
    cls.op  = opcode;
    cls.idx = index;
    cls.val = value;
    cls.st  = ST_OK;
    unique case (opcode)
      OP_SETLEN: begin
        if (int'(index) > MAX_TERMS) cls.st = ST_RANGE;
      end
      OP_WRITE, OP_ADD, OP_SUB, OP_READ: begin
        if (int'(index) >= MAX_TERMS) cls.st = ST_RANGE;
      end
      OP_DIVIDE: begin
        if (value == 32'sd0) cls.st = ST_DIV0;
      end
      default: begin
        cls.st = ST_OK;
      end
    endcase
  end

  assign busy    = fill == 2'd2;
  assign push    = start && !busy;
  assign q_valid = fill != 2'd0;
  assign pop     = q_pop && q_valid;
  assign q_cmd   = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/pce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_back: command execution
// Walk the coefficient store with a shared multiplier, an index multiplier and a shared divider.
// ----------------------------------------------------------------------------
module pce_back #(
  parameter int MAX_TERMS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  pce_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               done,
  output logic signed [31:0] result,
  output logic [1:0]         status,
  output logic [4:0]         term_count
);
  import pce_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_READ = 9'b000000010,
    S_EXEC = 9'b000000100,
    S_SCL  = 9'b000001000,
    S_PV   = 9'b000010000,
    S_PU   = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_DM   = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t             state;
  logic [3:0]         op;
  logic signed [31:0] val;
  logic [1:0]         st;
  logic [CW-1:0]      i;
  logic [CW-1:0]      cnt;
  logic [MAX_TERMS-1:0] valid;
  logic signed [31:0] p;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic signed [47:0] term;
  logic signed [31:0] rdv;

  logic [AW-1:0]      ia;
  logic [31:0]        rdata;
  logic signed [31:0] c;
  logic               walk, q_walk;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mprod;
  logic signed [31:0] simple_val;
  logic               we;
  logic signed [31:0] wdata;
  logic               div_start, div_done;
  logic signed [47:0] div_dividend;
  logic signed [31:0] div_divisor;
  logic signed [48:0] div_q;
  logic signed [47+CW+1:0] dm;

  function automatic logic is_walk(input logic [3:0] o);
    return o == OP_ADDSC || o == OP_SCMINUS || o == OP_SCALE ||
           o == OP_DIVIDE || o == OP_INTEG || o == OP_DERIV;
  endfunction

  assign ia     = i[AW-1:0];
  assign c      = valid[ia] ? $signed(rdata) : 32'sd0;
  assign walk   = is_walk(op);
  assign q_walk = is_walk(q_cmd.op);
  assign q_pop  = (state == S_IDLE) && q_valid;

  // shared multiplier: coefficient by power or scalar, then power by x
  assign mul_a = (state == S_PV) ? p : c;
  assign mul_b = (state == S_PV || op == OP_SCALE) ? val : p;
  assign mprod = mul_a * mul_b;
  assign dm    = term * $signed({1'b0, i});

  always_comb begin
    case (op)
      OP_WRITE:   simple_val = val;
      OP_ADD:     simple_val = sat32(64'(c) + 64'(val));
      OP_SUB:     simple_val = sat32(64'(c) - 64'(val));
      OP_ADDSC:   simple_val = sat32(64'(c) + 64'(val));
      OP_SCMINUS: simple_val = sat32(64'(val) - 64'(c));
      default:    simple_val = c;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = simple_val;
    if (state == S_EXEC && (op == OP_WRITE || op == OP_ADD || op == OP_SUB ||
                            op == OP_ADDSC || op == OP_SCMINUS)) begin
      we = 1'b1;
    end else if (state == S_SCL) begin
      we    = 1'b1;
      wdata = sat32(prod >>> 16);
    end else if (state == S_DIV && div_done && op == OP_DIVIDE) begin
      we    = 1'b1;
      wdata = sat32(64'(div_q));
    end
  end

  assign div_start    = (state == S_EXEC && op == OP_DIVIDE) ||
                        (state == S_PU && op == OP_INTEG);
  assign div_dividend = (state == S_EXEC) ? $signed({c, 16'h0000}) : term;
  assign div_divisor  = (state == S_EXEC) ? val : $signed(32'(i) + 32'd1);

  pce_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (ia),
    .wdata (wdata),
    .raddr (ia),
    .rdata (rdata)
  );

  pce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      valid <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            op  <= q_cmd.op;
            val <= q_cmd.val;
            st  <= q_cmd.st;
            acc <= '0;
            rdv <= '0;
            p   <= (q_cmd.op == OP_DERIV) ? Q_ONE : q_cmd.val;
            if (q_walk) begin
              i <= (q_cmd.op == OP_DERIV) ? CW'(1) : CW'(0);
            end else begin
              i <= CW'(q_cmd.idx);
            end
            if (q_cmd.st != ST_OK || q_cmd.op == OP_SETLEN || q_cmd.op > OP_READ) begin
              if (q_cmd.st == ST_OK && q_cmd.op == OP_SETLEN) begin
                valid <= '0;
                cnt   <= CW'(q_cmd.idx);
              end
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= (walk && i >= cnt) ? S_DONE : S_EXEC;
        end
        S_EXEC: begin
          case (op)
            OP_WRITE, OP_ADD, OP_SUB: begin
              valid[ia] <= 1'b1;
              if (cnt < i + CW'(1)) cnt <= i + CW'(1);
              state <= S_DONE;
            end
            OP_READ: begin
              rdv   <= c;
              state <= S_DONE;
            end
            OP_ADDSC, OP_SCMINUS: begin
              valid[ia] <= 1'b1;
              i     <= i + CW'(1);
              state <= S_READ;
            end
            OP_SCALE: begin
              prod  <= mprod;
              state <= S_SCL;
            end
            OP_DIVIDE: begin
              state <= S_DIV;
            end
            default: begin
              prod  <= mprod;
              state <= S_PV;
            end
          endcase
        end
        S_SCL: begin
          valid[ia] <= 1'b1;
          i     <= i + CW'(1);
          state <= S_READ;
        end
        S_PV: begin
          term  <= 48'(prod >>> 16);
          prod  <= mprod;
          state <= S_PU;
        end
        S_PU: begin
          p     <= sat32(prod >>> 16);
          state <= (op == OP_INTEG) ? S_DIV : S_DM;
        end
        S_DM: begin
          acc   <= acc + 64'(dm);
          i     <= i + CW'(1);
          state <= S_READ;
        end
        S_DIV: begin
          if (div_done) begin
            if (op == OP_DIVIDE) begin
              valid[ia] <= 1'b1;
            end else begin
              acc <= acc + 64'(div_q);
            end
            i     <= i + CW'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      status <= st;
      if (op == OP_INTEG || op == OP_DERIV) begin
        result <= (st == ST_OK) ? sat32(acc) : 32'sd0;
      end else begin
        result <= rdv;
      end
    end
  end

  assign term_count = 5'(cnt);

`ifndef ASSERT_OFF
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE))
    else $error("result strobe without a finished item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(cnt) <= MAX_TERMS)
    else $error("term count beyond store depth");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == S_DIV)
    else $error("divider started outside its wait state");
`endif

endmodule

>>> rtl/core/polynomial_coefficient_engine_core.sv
`timescale 1ns / 1ps
// Set length, errors and unused opcodes go from idle straight to done; write/add/sub/read
// pass through a read and an execute state first. Add scalar, scalar minus and scale walk
// every term in use; derivative walks the terms from index one; divide and integral are
// paced by the bit-serial divider, which both share.
// One item runs at a time; queued items wait until the back end is idle again.
// Synchronous active-high reset empties the queue and marks every coefficient zero.
// ----------------------------------------------------------------------------
// polynomial_coefficient_engine_core: Q16.16 polynomial coefficient engine
// Stores up to MAX_TERMS coefficients; edits, scales, divides and evaluates.
// ----------------------------------------------------------------------------
module polynomial_coefficient_engine_core #(
  parameter int MAX_TERMS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         opcode,
  input  logic [4:0]         index,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [31:0] result,
  output logic [1:0]         status,
  output logic [4:0]         term_count
);
  import pce_pkg::*;

  // queue handshake between intake and execution
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // Front end: accept and classify each item, hold it in the queue.
  pce_front #(.MAX_TERMS(MAX_TERMS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .opcode  (opcode),
    .index   (index),
    .value   (value),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // Back end: run one item over the coefficient store, strobe its result.
  pce_back #(.MAX_TERMS(MAX_TERMS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .done       (done),
    .result     (result),
    .status     (status),
    .term_count (term_count)
  );

endmodule
